@@ rtl/swm_pkg.sv @@
`default_nettype none

package swm_pkg;

  // Build defaults for the top-level parameters
  localparam int DEF_MAX_WINDOW = 31;
  localparam int DEF_DATA_WIDTH = 32;

  // Fixed field widths
  localparam int SAMPLE_W   = 32;
  localparam int WIN_W      = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Register reset values
  localparam logic [WIN_W-1:0]      RST_WINDOW_LENGTH  = WIN_W'(3);
  localparam logic [CFG_DATA_W-1:0] RST_FILL_VALUE     = '0;
  localparam logic                  RST_SIGNED_COMPARE = 1'b1;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH  = 2'd0,
    REG_FILL_VALUE     = 2'd1,
    REG_SIGNED_COMPARE = 2'd2
  } cfg_reg_t;

  // Register file outputs toward the datapath
  typedef struct packed {
    logic [WIN_W-1:0]      window_length;
    logic                  signed_compare;
    logic                  refill;
    logic [CFG_DATA_W-1:0] refill_value;
  } swm_cfg_t;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic refill;
    logic advance;
    logic signed_cmp;
  } swm_cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/swm_sample_if.sv @@
`default_nettype none

interface swm_sample_if import swm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ rtl/swm_median_if.sv @@
`default_nettype none

interface swm_median_if import swm_pkg::*;;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink (input valid, input median, output ready);
endinterface

`default_nettype wire

@@ rtl/swm_cfg.sv @@
`default_nettype none

module swm_cfg import swm_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output swm_cfg_t                   cfg
);

  logic [WIN_W-1:0]      win_r, win_nxt;
  logic [CFG_DATA_W-1:0] fill_r, fill_nxt;
  logic                  scmp_r, scmp_nxt;
  logic                  wr_en;
  logic                  refill;
  cfg_reg_t              reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_W-1:2]);

  always_comb begin
    win_nxt  = win_r;
    fill_nxt = fill_r;
    scmp_nxt = scmp_r;
    refill   = 1'b0;
    if (wr_en) begin
      case (reg_idx)
        REG_WINDOW_LENGTH: begin
          // drop even lengths and lengths whose low WIN_W bits exceed the cell count
          if (pwdata[0] && (CFG_DATA_W'(pwdata[WIN_W-1:0]) <= CFG_DATA_W'(MAX_WINDOW))) begin
            win_nxt = pwdata[WIN_W-1:0];
            refill  = 1'b1;
          end
        end
        REG_FILL_VALUE: begin
          fill_nxt = pwdata;
          refill   = 1'b1;
        end
        REG_SIGNED_COMPARE: begin
          scmp_nxt = pwdata[0];
          refill   = 1'b1;
        end
        default: begin
          refill = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= RST_WINDOW_LENGTH;
      fill_r <= RST_FILL_VALUE;
      scmp_r <= RST_SIGNED_COMPARE;
    end else begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
      scmp_r <= scmp_nxt;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_LENGTH:  prdata = CFG_DATA_W'(win_r);
      REG_FILL_VALUE:     prdata = fill_r;
      REG_SIGNED_COMPARE: prdata = CFG_DATA_W'(scmp_r);
      default:            prdata = '0;
    endcase
  end

  assign cfg.window_length  = win_r;
  assign cfg.signed_compare = scmp_r;
  assign cfg.refill         = refill;
  assign cfg.refill_value   = fill_nxt;

endmodule

`default_nettype wire

@@ rtl/swm_cell.sv @@
`default_nettype none

module swm_cell import swm_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int AGE_W      = 5,
  parameter int CELL_INDEX = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire swm_cell_ctrl_t        ctrl,
  input  wire logic [AGE_W-1:0]      last_idx,
  input  wire logic [DATA_WIDTH-1:0] sample_val,
  input  wire logic [DATA_WIDTH-1:0] fill_val,
  input  wire logic [DATA_WIDTH-1:0] left_val,
  input  wire logic [AGE_W-1:0]      left_age,
  input  wire logic                  left_rm,
  input  wire logic                  left_lt,
  input  wire logic [DATA_WIDTH-1:0] right_val,
  input  wire logic [AGE_W-1:0]      right_age,
  output logic      [DATA_WIDTH-1:0] slot_val,
  output logic      [AGE_W-1:0]      slot_age,
  output logic                       rm_out,
  output logic                       lt_out,
  output logic      [DATA_WIDTH-1:0] slot_val_nxt
);

  localparam logic [AGE_W-1:0] MY_IDX = AGE_W'(CELL_INDEX);

  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [AGE_W-1:0]      age_r, age_nxt;
  logic [DATA_WIDTH-1:0] sign_mask;
  logic                  active, is_last, rm_here, lt_here;
  logic [DATA_WIDTH-1:0] c_here_val, c_left_val;
  logic [AGE_W-1:0]      c_here_age, c_left_age;

  assign active  = (MY_IDX <= last_idx);
  assign is_last = (MY_IDX == last_idx);

  // oldest slot at or left of this cell: the compacted row pulls from the right
  assign rm_here    = left_rm | (active && (age_r == '0));
  assign c_here_val = rm_here ? right_val : val_r;
  assign c_here_age = rm_here ? right_age : age_r;
  assign c_left_val = left_rm ? val_r : left_val;
  assign c_left_age = left_rm ? age_r : left_age;

  assign sign_mask = {ctrl.signed_cmp, {(DATA_WIDTH-1){1'b0}}};
  assign lt_here   = is_last | ((sample_val ^ sign_mask) < (c_here_val ^ sign_mask));

  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r;
    if (ctrl.refill) begin
      val_nxt = fill_val;
      age_nxt = MY_IDX;
    end else if (ctrl.advance && active) begin
      if (left_lt) begin
        val_nxt = c_left_val;
        age_nxt = c_left_age - AGE_W'(1);
      end else if (lt_here) begin
        val_nxt = sample_val;
        age_nxt = last_idx;
      end else begin
        val_nxt = c_here_val;
        age_nxt = c_here_age - AGE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
      age_r <= MY_IDX;
    end else begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

  assign slot_val     = val_r;
  assign slot_age     = age_r;
  assign rm_out       = rm_here;
  assign lt_out       = lt_here;
  assign slot_val_nxt = val_nxt;

endmodule

`default_nettype wire

@@ rtl/sliding_window_median.sv @@
// Running median over a sliding window of samples.
//
// in_if carries one sample per transfer; out_if returns one median per
// accepted sample. The window is a row of MAX_WINDOW sort cells; each holds
// one value with its age and trades data with both neighbors. Every
// transfer drops the oldest slot, inserts the new sample after any equal
// values and registers the value at rank window_length/2.
// The median is registered and shown on out_if in the cycle after the input transfer.
// Throughput: one sample per cycle while out_if does not stall; each cell update
// compares against the compacted row and shifts by one place.
// Stall: while a median waits and out_if.ready is low, in_if.ready is low.
// Configuration (APB, byte address 4*i): window_length (odd, low WIN_W bits
// at most MAX_WINDOW, else dropped), fill_value, signed_compare. Any
// accepted write reloads every slot with fill_value and resets the ages.
// Reset: window_length 3, fill_value 0, signed compare; all slots 0 and
// no median pending.
`default_nettype none

module sliding_window_median import swm_pkg::*; #(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  swm_sample_if.sink                 in_if,
  swm_median_if.source               out_if,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int AGE_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  swm_cfg_t       cfg;
  swm_cell_ctrl_t ctrl;

  logic                  in_ready, in_xfer;
  logic                  out_valid_r;
  logic [SAMPLE_W-1:0]   out_median_r;
  logic [AGE_W-1:0]      last_idx, half_idx;
  logic [DATA_WIDTH-1:0] sample_val, fill_val;

  logic [DATA_WIDTH-1:0] slot_val     [MAX_WINDOW];
  logic [DATA_WIDTH-1:0] slot_val_nxt [MAX_WINDOW];
  logic [AGE_W-1:0]      slot_age     [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] rm_chain, lt_chain, zero_age;

  swm_cfg #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  // hold input while a median waits on a stalled receiver
  assign in_ready = !out_valid_r || out_if.ready;
  assign in_xfer  = in_if.valid && in_ready;
  assign in_if.ready = in_ready;

  assign ctrl.refill     = cfg.refill;
  assign ctrl.advance    = in_xfer;
  assign ctrl.signed_cmp = cfg.signed_compare;

  // window_length is odd, so (n-1)/2 equals n/2
  assign last_idx   = AGE_W'(cfg.window_length - WIN_W'(1));
  assign half_idx   = last_idx >> 1;
  assign sample_val = DATA_WIDTH'(in_if.sample);
  assign fill_val   = DATA_WIDTH'(cfg.refill_value);

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    localparam int L = (k > 0) ? k - 1 : 0;
    localparam int R = (k < MAX_WINDOW - 1) ? k + 1 : k;

    logic left_rm, left_lt;
    assign left_rm = (k > 0) ? rm_chain[L] : 1'b0;
    assign left_lt = (k > 0) ? lt_chain[L] : 1'b0;

    swm_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .AGE_W     (AGE_W),
      .CELL_INDEX(k)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .last_idx    (last_idx),
      .sample_val  (sample_val),
      .fill_val    (fill_val),
      .left_val    (slot_val[L]),
      .left_age    (slot_age[L]),
      .left_rm     (left_rm),
      .left_lt     (left_lt),
      .right_val   (slot_val[R]),
      .right_age   (slot_age[R]),
      .slot_val    (slot_val[k]),
      .slot_age    (slot_age[k]),
      .rm_out      (rm_chain[k]),
      .lt_out      (lt_chain[k]),
      .slot_val_nxt(slot_val_nxt[k])
    );

    assign zero_age[k] = (slot_age[k] == '0) && (AGE_W'(k) <= last_idx);
  end

  // advance the result register on every input transfer, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_median_r <= SAMPLE_W'(slot_val_nxt[half_idx]);
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.median = out_median_r;

  // every input transfer leaves a median pending
  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid_r)
    else $error("no median after input transfer");

  // a pending median is never overwritten while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_if.ready) |-> !in_ready)
    else $error("input taken while median stalled");

  // exactly one live slot is the oldest
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(zero_age))
    else $error("oldest slot not unique");

  // window length stays odd so the median rank is well defined
  a_odd_window: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.window_length[0])
    else $error("even window length");

  // a reload returns the ages to slot order; slot 0 is checked for age 0
  a_refill_ages: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.refill |=> (slot_age[0] == '0))
    else $error("ages not reset by reload");

endmodule

`default_nettype wire
